[hw/rtl/tvlt_pkg.sv]
// ----------------------------------------------------------------------------
// tvlt_pkg: shared types and constants of the tag/value line tokenizer
// Token kinds, error codes, parser modes, parser state and result bundle.
// ----------------------------------------------------------------------------
package tvlt_pkg;

  // room for the results one byte can cause; at most three are used
  localparam int MaxRes = 4;
  localparam int CntW   = $clog2(MaxRes + 1);
  localparam int IdxW   = $clog2(MaxRes);

  // character constants
  localparam logic [7:0] ChBom0  = 8'hEF;
  localparam logic [7:0] ChBom1  = 8'hBB;
  localparam logic [7:0] ChBom2  = 8'hBF;
  localparam logic [7:0] ChLow   = 8'h20;
  localparam logic [7:0] ChHigh  = 8'h7D;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChNul   = 8'h00;

  // mark_pos values: byte order mark progress, then past the file start
  localparam logic [1:0] MarkStart = 2'd0;
  localparam logic [1:0] MarkOne   = 2'd1;
  localparam logic [1:0] MarkTwo   = 2'd2;
  localparam logic [1:0] MarkDone  = 2'd3;

  typedef enum logic [2:0] {
    KIND_TAG_BYTE   = 3'd0,
    KIND_VALUE_BYTE = 3'd1,
    KIND_TAG_END    = 3'd2,
    KIND_ENTRY_END  = 3'd3,
    KIND_FILE_END   = 3'd4,
    KIND_ERROR      = 3'd5
  } item_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_ILLEGAL = 2'd1,
    ERR_EMPTY   = 2'd2,
    ERR_NULL    = 2'd3
  } err_code_t;

  typedef enum logic [1:0] {
    MODE_TAG    = 2'd0,
    MODE_VALUE  = 2'd1,
    MODE_MVALUE = 2'd2,
    MODE_INDENT = 2'd3
  } parse_mode_t;

  typedef struct packed {
    parse_mode_t mode;
    logic        nonempty;     // tag or single-line value has bytes
    logic        has_content;  // multiline value has a content byte
    logic [1:0]  mark_pos;     // byte order mark progress
    logic        failed;       // sticky error
  } parse_state_t;

  localparam parse_state_t StateReset = '{
    mode:        MODE_TAG,
    nonempty:    1'b0,
    has_content: 1'b0,
    mark_pos:    MarkStart,
    failed:      1'b0
  };

  typedef struct packed {
    item_kind_t kind;
    logic [7:0] data;
    err_code_t  err;
    logic       disc;
  } result_t;

  typedef struct packed {
    logic [CntW-1:0]          cnt;
    result_t [MaxRes-1:0]     res;
  } bundle_t;

  function automatic result_t make_res(item_kind_t kind, logic [7:0] data,
                                       err_code_t err, logic disc);
    result_t r;
    r.kind = kind;
    r.data = data;
    r.err  = err;
    r.disc = disc;
    return r;
  endfunction

endpackage

[hw/rtl/tvlt_in_if.sv]
// ----------------------------------------------------------------------------
// tvlt_in_if: input byte channel
// Valid/ready channel carrying one text byte and its end-of-file mark.
// ----------------------------------------------------------------------------
interface tvlt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

[hw/rtl/tvlt_out_if.sv]
// ----------------------------------------------------------------------------
// tvlt_out_if: token channel
// Valid/ready channel carrying one token result.
// ----------------------------------------------------------------------------
interface tvlt_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] item_kind;
  logic [7:0] out_byte;
  logic [1:0] error_code;
  logic       tag_discarded;
  logic       last_result;

  modport source (output valid, output item_kind, output out_byte, output error_code,
                  output tag_discarded, output last_result, input ready);
  modport sink   (input valid, input item_kind, input out_byte, input error_code,
                  input tag_discarded, input last_result, output ready);
endinterface

[hw/rtl/tvlt_step.sv]
// ----------------------------------------------------------------------------
// tvlt_step: per-byte parser decision
// Takes the parser state and one byte, gives the next state and the bundle
// of results (up to three) that the byte causes.
// ----------------------------------------------------------------------------
module tvlt_step
  import tvlt_pkg::*;
(
  input  parse_state_t st,
  input  logic [7:0]   data_byte,
  input  logic         last_byte,
  output parse_state_t st_next,
  output bundle_t      bundle
);

  always_comb begin
    parse_state_t    ns;
    bundle_t         b;
    logic [CntW-1:0] n;
    err_code_t       err;
    logic            do_tag;
    logic            do_flush;
    logic            disc;

    ns       = st;
    b        = '0;
    n        = '0;
    err      = ERR_NONE;
    do_tag   = 1'b0;
    do_flush = 1'b0;
    disc     = 1'b0;

    if (st.failed) begin
      // swallow bytes until end of file
      if (last_byte) ns = StateReset;
    end else begin
      // byte order mark tracking, then the line parser
      if (st.mark_pos == MarkStart && data_byte == ChBom0) begin
        if (last_byte) err = ERR_ILLEGAL;
        else ns.mark_pos = MarkOne;
      end else if (st.mark_pos == MarkOne) begin
        if (data_byte == ChBom1 && !last_byte) ns.mark_pos = MarkTwo;
        else err = ERR_ILLEGAL;
      end else if (st.mark_pos == MarkTwo) begin
        if (data_byte == ChBom2) begin
          ns.mark_pos = MarkDone;
          do_flush    = last_byte;
        end else begin
          err = ERR_ILLEGAL;
        end
      end else begin
        ns.mark_pos = MarkDone;
        if (data_byte == ChNul) begin
          err = ERR_NULL;
        end else begin
          case (st.mode)
            MODE_VALUE: begin
              if (data_byte != ChNl) begin
                b.res[n[IdxW-1:0]] = make_res(KIND_VALUE_BYTE, data_byte, ERR_NONE, 1'b0);
                n = n + 1'b1;
                ns.nonempty = 1'b1;
              end else if (!st.nonempty) begin
                // empty value opens a multiline value
                ns.mode        = MODE_INDENT;
                ns.has_content = 1'b0;
              end else begin
                b.res[n[IdxW-1:0]] = make_res(KIND_ENTRY_END, 8'h00, ERR_NONE, 1'b0);
                n = n + 1'b1;
                ns.mode     = MODE_TAG;
                ns.nonempty = 1'b0;
              end
            end
            MODE_MVALUE: begin
              if (data_byte != ChNl) begin
                b.res[n[IdxW-1:0]] = make_res(KIND_VALUE_BYTE, data_byte, ERR_NONE, 1'b0);
                n = n + 1'b1;
                ns.has_content = 1'b1;
              end else begin
                ns.mode = MODE_INDENT;
              end
            end
            MODE_INDENT: begin
              if (data_byte == ChTab) begin
                // continuation line: join with newline once content exists
                if (st.has_content) begin
                  b.res[n[IdxW-1:0]] = make_res(KIND_VALUE_BYTE, ChNl, ERR_NONE, 1'b0);
                  n = n + 1'b1;
                end
                ns.mode = MODE_MVALUE;
              end else begin
                // no tab: entry ends, byte is reparsed as a tag byte
                b.res[n[IdxW-1:0]] = make_res(KIND_ENTRY_END, 8'h00, ERR_NONE, 1'b0);
                n = n + 1'b1;
                ns.mode     = MODE_TAG;
                ns.nonempty = 1'b0;
                do_tag      = 1'b1;
              end
            end
            default: begin
              ns.mode = MODE_TAG;
              do_tag  = 1'b1;
            end
          endcase

          // tag character handling
          if (do_tag) begin
            if (!ns.nonempty && data_byte == ChNl) begin
              // blank line between entries
            end else if (data_byte != ChEq) begin
              if (data_byte < ChLow || data_byte > ChHigh) begin
                err = ERR_ILLEGAL;
              end else begin
                b.res[n[IdxW-1:0]] = make_res(KIND_TAG_BYTE, data_byte, ERR_NONE, 1'b0);
                n = n + 1'b1;
                ns.nonempty = 1'b1;
              end
            end else if (!ns.nonempty) begin
              err = ERR_EMPTY;
            end else begin
              b.res[n[IdxW-1:0]] = make_res(KIND_TAG_END, 8'h00, ERR_NONE, 1'b0);
              n = n + 1'b1;
              ns.mode     = MODE_VALUE;
              ns.nonempty = 1'b0;
            end
          end
        end
        do_flush = last_byte && (err == ERR_NONE);
      end

      // end of file: close the open entry, report file end
      if (do_flush) begin
        disc = (ns.mode == MODE_TAG) && ns.nonempty;
        if (ns.mode != MODE_TAG) begin
          b.res[n[IdxW-1:0]] = make_res(KIND_ENTRY_END, 8'h00, ERR_NONE, 1'b0);
          n = n + 1'b1;
        end
        b.res[n[IdxW-1:0]] = make_res(KIND_FILE_END, 8'h00, ERR_NONE, disc);
        n = n + 1'b1;
        ns = StateReset;
      end

      // error report, sticky until the last byte
      if (err != ERR_NONE) begin
        b.res[n[IdxW-1:0]] = make_res(KIND_ERROR, 8'h00, err, 1'b0);
        n = n + 1'b1;
        if (last_byte) ns = StateReset;
        else ns.failed = 1'b1;
      end
    end

    b.cnt   = n;
    st_next = ns;
    bundle  = b;
  end

endmodule

[hw/rtl/tag_value_line_tokenizer.sv]
// ----------------------------------------------------------------------------
// tag_value_line_tokenizer: streaming tokenizer for TAG=value text
// Input register, combinational parse step, result bundle register and an
// output serializer that hands out one token per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
// Bytes that cause no token or a single token stream at one per cycle while
// the token receiver is ready. A byte that causes k tokens (at most three,
// e.g. an entry end, a tag byte and a file end on the last byte) occupies
// the output serializer until its k tokens are taken, since the token port
// carries one token per cycle; the input register takes the next byte
// meanwhile. A byte enters the parse step when the result bundle register is
// empty or hands out its final token in that cycle. Tokens leave from the
// result bundle register, fed by the input register. The byte marked last
// closes the file and resets the parser, so the next byte begins a new file.
module tag_value_line_tokenizer
  import tvlt_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  tvlt_in_if.sink         byte_in,
  tvlt_out_if.source      token_out
);

  // input register
  logic         ireg_valid;
  logic [7:0]   ireg_byte;
  logic         ireg_last;

  // parser state and result bundle
  parse_state_t    pstate;
  parse_state_t    pstate_next;
  bundle_t         step_bundle;
  result_t [MaxRes-1:0] res;
  logic [CntW-1:0] res_cnt;
  logic [IdxW-1:0] res_idx;

  logic    in_acc;
  logic    out_acc;
  logic    res_last;
  logic    bundle_free;
  logic    advance;
  result_t cur;

  tvlt_step u_step (
    .st        (pstate),
    .data_byte (ireg_byte),
    .last_byte (ireg_last),
    .st_next   (pstate_next),
    .bundle    (step_bundle)
  );

  // handshake control
  assign cur         = res[res_idx];
  assign res_last    = ({1'b0, res_idx} + 1'b1) == res_cnt;
  assign out_acc     = token_out.valid && token_out.ready;
  assign bundle_free = (res_cnt == '0) || (out_acc && res_last);
  assign advance     = ireg_valid && bundle_free;
  assign in_acc      = byte_in.valid && byte_in.ready;

  assign byte_in.ready = !ireg_valid || bundle_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ireg_valid <= 1'b0;
    end else if (in_acc) begin
      ireg_valid <= 1'b1;
    end else if (advance) begin
      ireg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ireg_byte <= byte_in.data_byte;
      ireg_last <= byte_in.last_byte;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      pstate <= StateReset;
    end else if (advance) begin
      pstate <= pstate_next;
    end
  end

  // result bundle and serializer
  always_ff @(posedge clk) begin
    if (rst) begin
      res_cnt <= '0;
      res_idx <= '0;
    end else if (advance) begin
      res_cnt <= step_bundle.cnt;
      res_idx <= '0;
    end else if (out_acc) begin
      if (res_last) begin
        res_cnt <= '0;
        res_idx <= '0;
      end else begin
        res_idx <= res_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= step_bundle.res;
    end
  end

  // token port
  assign token_out.valid         = res_cnt != '0;
  assign token_out.item_kind     = cur.kind;
  assign token_out.out_byte      = cur.data;
  assign token_out.error_code    = cur.err;
  assign token_out.tag_discarded = cur.disc;
  assign token_out.last_result   = res_last;

endmodule
